// ===== sv/positional_ordered_list_top_assert.svh =====
// Assertion macros for the positional list block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef POSITIONAL_ORDERED_LIST_TOP_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_TOP_ASSERT_SVH

// same-cycle implication
`define POL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define POL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pol_pkg.sv =====
package pol_pkg;

	localparam int unsigned PosW = 5;
	localparam int unsigned ValW = 32;
	localparam int unsigned LenW = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_UP    = 2'd1,
		CELL_DOWN  = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic [1:0]             operation;
		logic [PosW-1:0]        position;
		logic signed [ValW-1:0] value_in;
	} in_item_t;

	typedef struct packed {
		logic signed [ValW-1:0] value_out;
		logic [LenW-1:0]        length;
		logic [1:0]             status;
	} out_item_t;

	typedef struct packed {
		cell_op_t               op;
		logic [PosW-1:0]        pos;
		logic signed [ValW-1:0] value;
	} cell_cmd_t;

endpackage

// ===== sv/positional_ordered_list_top.sv =====
// Channel   Handshake          Payload                     Direction
// -------   ----------------   -------------------------   ---------
// command   start / busy       cmd    (pol_pkg::in_item_t)  in
// result    done (strobe)      result (pol_pkg::out_item_t) out
//
// An item is accepted when start is high and busy is low, and its result
// shows on result with done high in the next cycle. busy stays low, so one
// item may be accepted on every edge; on insert or remove the row of cells
// moves the entries from the addressed position on one place in that same edge.
// Reset (arst_n low) empties the list; entry contents are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
`include "positional_ordered_list_top_assert.svh"

module positional_ordered_list_top #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pol_pkg::in_item_t   cmd,
	output logic                done,
	output pol_pkg::out_item_t  result
);

	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam int unsigned CmpW = ((CntW > pol_pkg::PosW) ? CntW : pol_pkg::PosW) + 1;

	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  count_nxt;
	logic             done_q;
	pol_pkg::out_item_t result_q;
	pol_pkg::out_item_t result_nxt;
	pol_pkg::cell_cmd_t cell_cmd;

	logic             accept;
	logic             full;
	logic             pos_nz;
	logic             ins_ok;
	logic             rd_ok;
	logic [CmpW-1:0]  pos_x;
	logic [CmpW-1:0]  cnt_x;
	logic signed [pol_pkg::ValW-1:0] rd_bus;

	logic signed [pol_pkg::ValW-1:0] cell_data [DEPTH];
	logic signed [pol_pkg::ValW-1:0] cell_rd   [DEPTH];

	// Every item is handled without a stall, so the command side never waits.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Range checks: insert may land at 1..count+1, remove/query at 1..count.
	assign full   = (count_q == CntW'(DEPTH));
	assign pos_x  = CmpW'(cmd.position);
	assign cnt_x  = CmpW'(count_q);
	assign pos_nz = (cmd.position != '0);
	assign ins_ok = !full && pos_nz && (pos_x <= cnt_x + 1'b1);
	assign rd_ok  = pos_nz && (pos_x <= cnt_x);

	// Read bus: only the addressed cell drives nonzero data, so OR them.
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	// Decode the item into a broadcast cell command and the result word.
	always_comb begin
		cell_cmd.op    = pol_pkg::CELL_HOLD;
		cell_cmd.pos   = cmd.position;
		cell_cmd.value = cmd.value_in;
		count_nxt      = count_q;
		result_nxt.value_out = '0;
		result_nxt.status    = pol_pkg::ST_OK;
		case (cmd.operation)
			pol_pkg::OP_INSERT: begin
				if (full) begin
					result_nxt.status = pol_pkg::ST_FULL;
				end else if (!ins_ok) begin
					result_nxt.status = pol_pkg::ST_RANGE;
				end else begin
					cell_cmd.op = pol_pkg::CELL_UP;
					count_nxt   = count_q + 1'b1;
				end
			end
			pol_pkg::OP_REMOVE: begin
				if (!rd_ok) begin
					result_nxt.status = pol_pkg::ST_RANGE;
				end else begin
					cell_cmd.op          = pol_pkg::CELL_DOWN;
					result_nxt.value_out = rd_bus;
					count_nxt            = count_q - 1'b1;
				end
			end
			pol_pkg::OP_QUERY: begin
				if (!rd_ok) begin
					result_nxt.status = pol_pkg::ST_RANGE;
				end else begin
					result_nxt.value_out = rd_bus;
				end
			end
			default: begin
				// unused code: drop the item, report out of range
				result_nxt.status = pol_pkg::ST_RANGE;
			end
		endcase
		// length is the count masked to the field width
		result_nxt.length = pol_pkg::LenW'(count_nxt);
		if (!accept) begin
			cell_cmd.op = pol_pkg::CELL_HOLD;
			count_nxt   = count_q;
		end
	end

	// Row of cells: cell i holds position i+1; on insert the addressed cell takes the new value
	// and cells past it take from left, on remove cells from the addressed one on take from right.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		pol_cell #(
			.IDX (g)
		) u_cell (
			.clk   (clk),
			.cmd   (cell_cmd),
			.left  (cell_data[(g == 0) ? 0 : g - 1]),
			.right (cell_data[(g == DEPTH - 1) ? g : g + 1]),
			.data  (cell_data[g]),
			.rd    (cell_rd[g])
		);
	end

	// Hold count and the done strobe; count moves on each accepted insert or remove that is in range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	// Result payload register, no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_nxt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`POL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(DEPTH), "count exceeds depth")
	`POL_ASSERT_NEXT(a_done_follows, accept, done, "accepted item gave no result")
	`POL_ASSERT_NEXT(a_no_spurious, !accept, !done, "result without an item")
	`POL_ASSERT_NOW(a_fail_zero, done && (result.status != pol_pkg::ST_OK), result.value_out == '0, "failed item returned data")
	`POL_ASSERT_NEXT(a_ins_count, accept && (cmd.operation == pol_pkg::OP_INSERT) && ins_ok, count_q == $past(count_q) + 1'b1, "insert did not grow the list")

endmodule

// ===== sv/pol_cell.sv =====
module pol_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                                 clk,
	input  pol_pkg::cell_cmd_t                   cmd,
	input  logic signed [pol_pkg::ValW-1:0]      left,
	input  logic signed [pol_pkg::ValW-1:0]      right,
	output logic signed [pol_pkg::ValW-1:0]      data,
	output logic signed [pol_pkg::ValW-1:0]      rd
);

	logic signed [pol_pkg::ValW-1:0] data_q;
	logic signed [pol_pkg::ValW-1:0] nxt;
	logic                            load;
	logic                            at_pos;
	logic                            below_me;

	// this cell holds 1-based position IDX+1
	assign at_pos   = (32'(cmd.pos) == 32'(IDX + 1));
	assign below_me = (32'(cmd.pos) <  32'(IDX + 1));

	always_comb begin
		nxt  = data_q;
		load = 1'b0;
		case (cmd.op)
			pol_pkg::CELL_UP: begin
				if (at_pos) begin
					nxt  = cmd.value;
					load = 1'b1;
				end else if (below_me) begin
					nxt  = left;
					load = 1'b1;
				end
			end
			pol_pkg::CELL_DOWN: begin
				if (at_pos || below_me) begin
					nxt  = right;
					load = 1'b1;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= nxt;
		end
	end

	assign data = data_q;
	// drive the shared read bus only when addressed
	assign rd   = at_pos ? data_q : '0;

endmodule

// ===== dv/pol_list_checker.sv =====
`timescale 1ns / 100ps

module pol_list_checker #(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  pol_pkg::in_item_t  cmd,
	input  logic               done,
	input  pol_pkg::out_item_t result,
	output int                 fails,
	output int                 waiting
);

	logic signed [pol_pkg::ValW-1:0] slots [DEPTH];
	int                              held;
	int                              miss;
	pol_pkg::out_item_t              pending_results [$];
	pol_pkg::out_item_t              want;

	// apply one item to the list copy and return the result it should produce
	function automatic pol_pkg::out_item_t list_apply(input pol_pkg::in_item_t it);
		pol_pkg::out_item_t r;
		int                 p;
		r        = '0;
		p        = int'(it.position);
		r.status = pol_pkg::ST_OK;
		case (it.operation)
			pol_pkg::OP_INSERT: begin
				if (held >= int'(DEPTH)) begin
					r.status = pol_pkg::ST_FULL;
				end else if (p < 1 || p > held + 1) begin
					r.status = pol_pkg::ST_RANGE;
				end else begin
					for (int i = held; i >= p; i--) slots[i] = slots[i-1];
					slots[p-1] = it.value_in;
					held++;
				end
			end
			pol_pkg::OP_REMOVE: begin
				if (p < 1 || p > held) begin
					r.status = pol_pkg::ST_RANGE;
				end else begin
					r.value_out = slots[p-1];
					for (int i = p; i < held; i++) slots[i-1] = slots[i];
					held--;
				end
			end
			pol_pkg::OP_QUERY: begin
				if (p < 1 || p > held) r.status = pol_pkg::ST_RANGE;
				else r.value_out = slots[p-1];
			end
			default: r.status = pol_pkg::ST_RANGE;
		endcase
		r.length = held[pol_pkg::LenW-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_results.delete();
			held = 0;
			waiting <= 0;
		end else begin
			// compare first: a result at this edge belongs to an earlier item
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result strobe with no item outstanding");
					miss++;
				end else begin
					want = pending_results.pop_front();
					if (result.value_out !== want.value_out) begin
						$error("value_out: expected %0d, got %0d",
							want.value_out, result.value_out);
						miss++;
					end
					if (result.length !== want.length) begin
						$error("length: expected %0d, got %0d", want.length, result.length);
						miss++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						miss++;
					end
				end
			end
			if (start && !busy) pending_results.push_back(list_apply(cmd));
			waiting <= pending_results.size();
		end
		fails <= miss;
	end

endmodule

// ===== dv/positional_ordered_list_top_tb.sv =====
`timescale 1ns / 100ps

module positional_ordered_list_top_tb;

	localparam int unsigned Depth      = 16;
	localparam logic [1:0]  OpUnused   = 2'd3;
	localparam int          CycleLimit = 200000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	pol_pkg::in_item_t  cmd;
	logic               done;
	pol_pkg::out_item_t result;
	int                 fails;
	int                 waiting;
	int                 cycles;
	int                 idle_pct;
	int                 fill;
	int                 grow_pct;

	positional_ordered_list_top #(
		.DEPTH(Depth)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	// watch both channels, predict every item and compare its result
	pol_list_checker #(
		.DEPTH(Depth)
	) i_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result),
		.fails  (fails),
		.waiting(waiting)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: end a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic pol_pkg::in_item_t make_item(input logic [1:0] op, input int pos,
		input logic [31:0] val);
		pol_pkg::in_item_t it;
		it.operation = op;
		it.position  = pos[pol_pkg::PosW-1:0];
		it.value_in  = val;
		return it;
	endfunction

	// Present one item and hold it until taken. Drop start only when a gap
	// is drawn, so a back-to-back item never sees start lowered and raised
	// in the same step.
	task automatic send_item(input pol_pkg::in_item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= it;
		do @(posedge clk); while (busy);
		// track the list length only to steer positions into range
		case (it.operation)
			pol_pkg::OP_INSERT: begin
				if (fill < int'(Depth) && it.position >= 1 && it.position <= fill + 1)
					fill++;
			end
			pol_pkg::OP_REMOVE: begin
				if (it.position >= 1 && it.position <= fill) fill--;
			end
			default: ;
		endcase
	endtask

	// Mostly in-range operations with random content; the growth bias is
	// redrawn now and then so the list swings between empty and full.
	// The rest is noise over every code and every position the field holds.
	task automatic run_random(input int n, input int pct);
		pol_pkg::in_item_t it;
		logic [31:0]       v;
		idle_pct = pct;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0) grow_pct = $urandom_range(25, 75);
			v = $urandom();
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0:       v = 32'h8000_0000;
					1:       v = 32'h7fff_ffff;
					2:       v = '0;
					default: v = '1;
				endcase
			end
			if ($urandom_range(0, 99) < 15) begin
				it = make_item(2'($urandom_range(0, 3)), $urandom_range(0, 31), v);
			end else if (fill == 0 || $urandom_range(0, 99) < grow_pct) begin
				it = make_item(pol_pkg::OP_INSERT, $urandom_range(1, fill + 1), v);
			end else begin
				it = make_item($urandom_range(0, 1) ? pol_pkg::OP_REMOVE : pol_pkg::OP_QUERY,
					$urandom_range(1, fill), v);
			end
			send_item(it);
		end
	endtask

	initial begin
		logic [31:0] v;
		arst_n   <= 1'b0;
		start    <= 1'b0;
		cmd      <= '0;
		idle_pct = 0;
		fill     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every read and every bad insert position is out of range
		send_item(make_item(pol_pkg::OP_QUERY, 1, 32'h0));
		send_item(make_item(pol_pkg::OP_REMOVE, 1, 32'hdead_beef));
		send_item(make_item(pol_pkg::OP_INSERT, 2, 32'h1));
		send_item(make_item(pol_pkg::OP_INSERT, 0, 32'h2));

		// fill to capacity at front, end and middle, extremes first
		for (int k = 0; k < int'(Depth); k++) begin
			case (k)
				0:       v = 32'h8000_0000;
				1:       v = 32'h7fff_ffff;
				2:       v = '0;
				3:       v = '1;
				default: v = $urandom();
			endcase
			case (k % 3)
				0:       send_item(make_item(pol_pkg::OP_INSERT, 1, v));
				1:       send_item(make_item(pol_pkg::OP_INSERT, fill + 1, v));
				default: send_item(make_item(pol_pkg::OP_INSERT, fill / 2 + 1, v));
			endcase
		end

		// full list: the full flag wins over a bad position
		send_item(make_item(pol_pkg::OP_INSERT, 31, 32'h1234_5678));
		send_item(make_item(pol_pkg::OP_INSERT, 5, 32'h8765_4321));
		send_item(make_item(pol_pkg::OP_QUERY, 16, 32'h0));
		send_item(make_item(pol_pkg::OP_QUERY, 17, 32'h0));
		// unused code leaves the list alone
		send_item(make_item(OpUnused, 3, 32'hffff_0000));
		send_item(make_item(pol_pkg::OP_REMOVE, 16, 32'h0));
		send_item(make_item(pol_pkg::OP_REMOVE, 1, 32'h0));
		send_item(make_item(pol_pkg::OP_QUERY, 0, 32'h0));
		send_item(make_item(pol_pkg::OP_REMOVE, 31, '1));

		// sender idling: light, heavy, then none
		run_random(317, 28);
		run_random(317, 57);
		run_random(316, 0);
		start <= 1'b0;

		// drain: wait for the last result, then a few quiet cycles
		do @(posedge clk); while (waiting != 0);
		repeat (4) @(posedge clk);
		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
